// ===== hw/rtl/joystick_axis_conditioner_macros.svh =====
// ----------------------------------------------------------------------------
// Joystick axis conditioner assertion macros
// Shared concurrent assertion forms. They expect clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_AXIS_CONDITIONER_MACROS_SVH
`define JOYSTICK_AXIS_CONDITIONER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define JAC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("jac: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define JAC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("jac: next-cycle check failed");

`endif

// ===== hw/rtl/jac_pkg.sv =====
// ----------------------------------------------------------------------------
// Joystick axis conditioner package
// Widths, codes and the queue word shared by the front, queue and back parts.
// ----------------------------------------------------------------------------
package jac_pkg;

  localparam int NUM_AXES    = 6;
  localparam int AXIS_W      = 3;
  localparam int AXIS_IDX_W  = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int SAMPLE_W    = 16;
  localparam int MAG_W       = 17;
  localparam int DZ_W        = 16;
  localparam int VALUE_W     = 13;
  localparam int STORE_W     = 17;
  localparam int PCT_W       = 7;
  localparam int CFG_IDX_W   = 3;

  // Serial divider: 16 quotient bits, two per cycle.
  localparam int QUO_W          = 16;
  localparam int NUM_W          = 31;
  localparam int DIV_RADIX_BITS = 2;
  localparam int DIV_CYCLES     = QUO_W / DIV_RADIX_BITS;

  localparam int FIFO_DEPTH = 2;

  localparam logic [DZ_W-1:0]           AXIS_FULL  = 16'd32767;
  localparam logic signed [STORE_W-1:0] TRIG_LEVEL = 17'sd16384;
  localparam logic [PCT_W-1:0]          PCT_MAX    = 7'd100;

  typedef enum logic [1:0] {
    KIND_MOVE    = 2'd0,
    KIND_LOOK_H  = 2'd1,
    KIND_LOOK_V  = 2'd2,
    KIND_TRIGGER = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    KEY_NONE    = 2'd0,
    KEY_PRESS   = 2'd1,
    KEY_RELEASE = 2'd2
  } key_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_EN   = 3'd0,
    CFG_LEFT_PCT  = 3'd1,
    CFG_RIGHT_EN  = 3'd2,
    CFG_RIGHT_PCT = 3'd3,
    CFG_ANALOG    = 3'd4
  } cfg_reg_e;

  // One classified item as it waits between the front and the back.
  typedef struct packed {
    kind_e                 kind;
    logic                  axis_ok;
    logic [AXIS_IDX_W-1:0] idx;
    logic [SAMPLE_W-1:0]   sample;
    logic                  neg;
    logic [MAG_W-1:0]      mag;
    logic [DZ_W-1:0]       dz;
    logic                  analog;
  } item_t;

endpackage

// ===== hw/rtl/jac_front.sv =====
// ----------------------------------------------------------------------------
// Joystick axis conditioner front
// Holds the configuration registers, accepts input words and classifies them
// (axis range, magnitude, deadzone) into queue words.
// ----------------------------------------------------------------------------
module jac_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         kind_i,
  input  logic [jac_pkg::AXIS_W-1:0]         axis_i,
  input  logic signed [jac_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [jac_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [jac_pkg::PCT_W-1:0]          cfg_data_i,
  input  logic                               full_i,
  output logic                               push_o,
  output jac_pkg::item_t                     entry_o
);

  localparam logic [13:0] RECIP_100 = 14'd10486;
  localparam logic [jac_pkg::AXIS_W:0] AXIS_LIMIT = (jac_pkg::AXIS_W + 1)'(jac_pkg::NUM_AXES);

  logic                        left_en_q;
  logic [jac_pkg::PCT_W-1:0]   left_pct_q;
  logic                        right_en_q;
  logic [jac_pkg::PCT_W-1:0]   right_pct_q;
  logic                        analog_q;

  logic                        use_left;
  logic                        dz_en;
  logic [jac_pkg::PCT_W-1:0]   pct_raw;
  logic [jac_pkg::PCT_W-1:0]   pct_c;
  logic [12:0]                 frac_num;
  logic [26:0]                 frac_prod;
  logic [jac_pkg::DZ_W-1:0]    dz_base;
  logic [jac_pkg::DZ_W-1:0]    dz_calc;
  logic [jac_pkg::MAG_W-1:0]   sample_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_en_q   <= 1'b0;
      left_pct_q  <= '0;
      right_en_q  <= 1'b0;
      right_pct_q <= '0;
      analog_q    <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        jac_pkg::CFG_LEFT_EN:   left_en_q   <= cfg_data_i[0];
        jac_pkg::CFG_LEFT_PCT:  left_pct_q  <= cfg_data_i;
        jac_pkg::CFG_RIGHT_EN:  right_en_q  <= cfg_data_i[0];
        jac_pkg::CFG_RIGHT_PCT: right_pct_q <= cfg_data_i;
        jac_pkg::CFG_ANALOG:    analog_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  always_comb begin
    use_left = (axis_i < 3'd2);
    dz_en    = use_left ? left_en_q : right_en_q;
    pct_raw  = use_left ? left_pct_q : right_pct_q;
    pct_c    = (pct_raw > jac_pkg::PCT_MAX) ? jac_pkg::PCT_MAX : pct_raw;
    // 32767 * p = 327 * 100 * p + 67 * p, so only (67 * p + 50) / 100 needs a
    // reciprocal, which is exact for all operands below 43690.
    frac_num  = 13'({6'd0, pct_c} * 13'd67 + 13'd50);
    frac_prod = {14'd0, frac_num} * {13'd0, RECIP_100};
    dz_base   = 16'({9'd0, pct_c} * 16'd327);
    dz_calc   = dz_base + {9'd0, frac_prod[26:20]};

    sample_ext = {sample_i[jac_pkg::SAMPLE_W-1], sample_i};

    entry_o.kind    = jac_pkg::kind_e'(kind_i);
    entry_o.axis_ok = ({1'b0, axis_i} < AXIS_LIMIT);
    entry_o.idx     = axis_i[jac_pkg::AXIS_IDX_W-1:0];
    entry_o.sample  = sample_i;
    entry_o.neg     = sample_i[jac_pkg::SAMPLE_W-1];
    entry_o.mag     = sample_i[jac_pkg::SAMPLE_W-1] ? (~sample_ext + 17'd1) : sample_ext;
    entry_o.dz      = dz_en ? dz_calc : '0;
    entry_o.analog  = analog_q;
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

// ===== hw/rtl/jac_fifo.sv =====
// ----------------------------------------------------------------------------
// Joystick axis conditioner queue
// Short first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
module jac_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  jac_pkg::item_t entry_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output jac_pkg::item_t head_o
);

  localparam int PTR_W = (jac_pkg::FIFO_DEPTH > 1) ? $clog2(jac_pkg::FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(jac_pkg::FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(jac_pkg::FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(jac_pkg::FIFO_DEPTH);

  jac_pkg::item_t   mem_q [jac_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push;
  logic             do_pop;

  assign full_o       = (cnt_q == CNT_FULL);
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== hw/rtl/jac_div.sv =====
// ----------------------------------------------------------------------------
// Joystick axis conditioner divider
// Restoring unsigned divider, two quotient bits per cycle. The caller
// guarantees that the quotient fits in 16 bits.
// ----------------------------------------------------------------------------
module jac_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [jac_pkg::NUM_W-1:0]     num_i,
  input  logic [jac_pkg::DZ_W-1:0]      den_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [jac_pkg::QUO_W-1:0]     quo_o
);

  localparam int CNT_W = (jac_pkg::DIV_CYCLES > 1) ? $clog2(jac_pkg::DIV_CYCLES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(jac_pkg::DIV_CYCLES - 1);

  logic                        busy_q;
  logic                        done_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [jac_pkg::DZ_W-1:0]    rem_q;
  logic [jac_pkg::QUO_W-1:0]   shf_q;
  logic [jac_pkg::DZ_W-1:0]    den_q;
  logic [jac_pkg::DZ_W-1:0]    rem_d;
  logic [jac_pkg::QUO_W-1:0]   shf_d;

  // The low register shifts the remaining dividend bits out at the top and
  // the quotient bits in at the bottom.
  always_comb begin
    logic [jac_pkg::DZ_W:0] trial;
    logic                   ge;
    rem_d = rem_q;
    shf_d = shf_q;
    for (int i = 0; i < jac_pkg::DIV_RADIX_BITS; i++) begin
      trial = {rem_d, shf_d[jac_pkg::QUO_W-1]};
      ge    = (trial >= {1'b0, den_q});
      shf_d = {shf_d[jac_pkg::QUO_W-2:0], ge};
      rem_d = ge ? jac_pkg::DZ_W'(trial - {1'b0, den_q}) : trial[jac_pkg::DZ_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CNT_LAST);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= jac_pkg::DZ_W'(num_i[jac_pkg::NUM_W-1:jac_pkg::QUO_W]);
      shf_q <= num_i[jac_pkg::QUO_W-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      shf_q <= shf_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = shf_q;

endmodule

// ===== hw/rtl/jac_back.sv =====
// ----------------------------------------------------------------------------
// Joystick axis conditioner back
// Takes classified words from the queue, runs the deadzone rescale and the
// move scaling on the shared divider, tracks trigger edges per axis and
// holds the output register.
// ----------------------------------------------------------------------------
`include "joystick_axis_conditioner_macros.svh"

module jac_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                head_valid_i,
  input  jac_pkg::item_t                      head_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [jac_pkg::VALUE_W-1:0]  value_o,
  output logic [1:0]                          key_event_o
);

  localparam logic [jac_pkg::NUM_W-1:0] MOVE_SCALE = 31'd100;
  localparam logic [jac_pkg::NUM_W-1:0] MOVE_ROUND = 31'd16383;
  localparam logic [jac_pkg::QUO_W-1:0] MOVE_CAP   = 16'd100;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_e;

  state_e                              state_q;
  jac_pkg::kind_e                      kind_q;
  logic                                neg_q;
  logic [jac_pkg::AXIS_IDX_W-1:0]      idx_q;
  logic                                analog_q;
  logic                                pass2_q;
  logic [jac_pkg::VALUE_W-1:0]         res_value_q;
  jac_pkg::key_e                       res_key_q;
  logic                                out_valid_q;
  logic [jac_pkg::VALUE_W-1:0]         out_value_q;
  jac_pkg::key_e                       out_key_q;
  logic signed [jac_pkg::STORE_W-1:0]  store_q [jac_pkg::NUM_AXES];

  logic                                pop;
  logic                                out_free;
  logic [jac_pkg::MAG_W-1:0]           diff;
  logic [31:0]                         prod1;
  logic                                rescale;
  logic signed [jac_pkg::STORE_W-1:0]  prev;
  logic signed [jac_pkg::STORE_W-1:0]  sample_ext;
  logic                                trig_now;
  logic                                trig_prev;
  jac_pkg::key_e                       trig_key;
  logic [jac_pkg::QUO_W-1:0]           quo;
  logic [jac_pkg::MAG_W-1:0]           qx;
  logic [jac_pkg::STORE_W-1:0]         r_val;
  logic [jac_pkg::VALUE_W-1:0]         look_mag;
  logic [jac_pkg::VALUE_W-1:0]         look_val;
  logic [jac_pkg::VALUE_W-1:0]         digital_val;
  logic [jac_pkg::PCT_W-1:0]           cap;
  logic [jac_pkg::VALUE_W-1:0]         analog_val;
  logic [jac_pkg::NUM_W-1:0]           num2;
  logic                                go_pass2;
  logic                                div_start;
  logic [jac_pkg::NUM_W-1:0]           div_num;
  logic [jac_pkg::DZ_W-1:0]            div_den;
  logic                                div_busy;
  logic                                div_done;

  jac_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_comb begin
    pop      = (state_q == S_IDLE) && head_valid_i;
    out_free = !out_valid_q || out_ready_i;

    // (mag - dz) * 32767 as a shift and a subtract.
    diff    = head_i.mag - {1'b0, head_i.dz};
    prod1   = {diff, 15'd0} - {15'd0, diff};
    rescale = head_i.axis_ok && (head_i.kind != jac_pkg::KIND_TRIGGER) &&
              (head_i.mag > {1'b0, head_i.dz}) && (head_i.dz != jac_pkg::AXIS_FULL);

    prev       = store_q[head_i.idx];
    sample_ext = {head_i.sample[jac_pkg::SAMPLE_W-1], head_i.sample};
    trig_now   = (sample_ext >= jac_pkg::TRIG_LEVEL);
    trig_prev  = (prev >= jac_pkg::TRIG_LEVEL);
    if (trig_now && !trig_prev) begin
      trig_key = jac_pkg::KEY_PRESS;
    end else if (!trig_now && trig_prev) begin
      trig_key = jac_pkg::KEY_RELEASE;
    end else begin
      trig_key = jac_pkg::KEY_NONE;
    end

    qx    = {1'b0, quo};
    r_val = neg_q ? (~qx + 17'd1) : qx;

    // A negative value shifts toward minus infinity, hence the rounding up
    // of the magnitude.
    look_mag    = neg_q ? jac_pkg::VALUE_W'((qx + 17'd15) >> 4) : jac_pkg::VALUE_W'(qx >> 4);
    look_val    = (neg_q ^ (kind_q == jac_pkg::KIND_LOOK_V)) ? (~look_mag + 13'd1) : look_mag;
    digital_val = neg_q ? '1 : 13'd1;

    cap        = (quo > MOVE_CAP) ? jac_pkg::PCT_MAX : quo[jac_pkg::PCT_W-1:0];
    analog_val = neg_q ? (~{6'd0, cap} + 13'd1) : {6'd0, cap};

    num2 = {15'd0, quo} * MOVE_SCALE + MOVE_ROUND;

    go_pass2  = (state_q == S_DIV) && div_done && !pass2_q &&
                (kind_q == jac_pkg::KIND_MOVE) && analog_q;
    div_start = (pop && rescale) || go_pass2;
    div_num   = (state_q == S_IDLE) ? prod1[jac_pkg::NUM_W-1:0] : num2;
    div_den   = (state_q == S_IDLE) ? (jac_pkg::AXIS_FULL - head_i.dz) : jac_pkg::AXIS_FULL;
  end

  assign pop_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= jac_pkg::KIND_MOVE;
      neg_q       <= 1'b0;
      idx_q       <= '0;
      analog_q    <= 1'b0;
      pass2_q     <= 1'b0;
      res_value_q <= '0;
      res_key_q   <= jac_pkg::KEY_NONE;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_key_q   <= jac_pkg::KEY_NONE;
      for (int i = 0; i < jac_pkg::NUM_AXES; i++) begin
        store_q[i] <= '0;
      end
    end else begin
      // In the emit state the output register is reloaded below instead.
      if (out_valid_q && out_ready_i && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (pop) begin
            kind_q      <= head_i.kind;
            neg_q       <= head_i.neg;
            idx_q       <= head_i.idx;
            analog_q    <= head_i.analog;
            pass2_q     <= 1'b0;
            res_value_q <= '0;
            res_key_q   <= jac_pkg::KEY_NONE;
            if (!head_i.axis_ok) begin
              state_q <= S_EMIT;
            end else if (head_i.kind == jac_pkg::KIND_TRIGGER) begin
              res_key_q            <= trig_key;
              store_q[head_i.idx]  <= sample_ext;
              state_q              <= S_EMIT;
            end else if (!rescale) begin
              // Inside the deadzone the axis reads as centered.
              store_q[head_i.idx] <= '0;
              state_q             <= S_EMIT;
            end else begin
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (!pass2_q) begin
              store_q[idx_q] <= r_val;
              if (go_pass2) begin
                pass2_q <= 1'b1;
              end else begin
                res_value_q <= (kind_q == jac_pkg::KIND_MOVE) ? digital_val : look_val;
                state_q     <= S_EMIT;
              end
            end else begin
              res_value_q <= analog_val;
              state_q     <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_value_q <= res_value_q;
            out_key_q   <= res_key_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = $signed(out_value_q);
  assign key_event_o = out_key_q;

  `JAC_ASSERT_IMPL(a_div_start_when_free, div_start, !div_busy)
  `JAC_ASSERT_IMPL(a_div_runs_in_div_state, state_q == S_DIV, div_busy || div_done)
  `JAC_ASSERT_IMPL(a_trigger_word_no_value, out_valid_q && (out_key_q != jac_pkg::KEY_NONE), out_value_q == '0)
  `JAC_ASSERT_NEXT(a_emit_loads_output, (state_q == S_EMIT) && out_free, out_valid_q && (state_q == S_IDLE))

endmodule

// ===== hw/rtl/joystick_axis_conditioner.sv =====
// ----------------------------------------------------------------------------
// Joystick axis conditioner
// Deadzone cut and rescale of controller axis samples, with move, look and
// trigger-edge outputs.
// ----------------------------------------------------------------------------
// Input words (kind_i, axis_i, sample_i) are taken on in_valid_i & in_ready_o
// into a two-word queue; in_ready_o drops only while that queue is full.
// Each input word gives exactly one output word (value_o, key_event_o) on the
// out_valid_o / out_ready_i channel, in order.
// Trigger words, words on an unused axis and samples inside the deadzone skip
// the divider; look words and digital move words that need the rescale use it
// once, analog move words twice. The back part handles one word at a time and
// pops the next only after the last has reached the output register. The serial
// divider makes two quotient bits a cycle and is used once for the rescale and
// once more for the percent scaling of analog move.
// When the receiver stalls, the result stays in the output register while the
// queue keeps taking words until it is full.
// Configuration writes (cfg_index_i, cfg_data_i) are always taken and should
// only be issued while the block is idle. Reset restores the register
// defaults (analog move on, deadzones off) and clears every stored axis value.
module joystick_axis_conditioner (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          kind_i,
  input  logic [jac_pkg::AXIS_W-1:0]          axis_i,
  input  logic signed [jac_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [jac_pkg::VALUE_W-1:0]  value_o,
  output logic [1:0]                          key_event_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [jac_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [jac_pkg::PCT_W-1:0]           cfg_data_i
);

  logic           push;
  logic           full;
  logic           pop;
  logic           head_valid;
  jac_pkg::item_t entry;
  jac_pkg::item_t head;

  jac_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .axis_i      (axis_i),
    .sample_i    (sample_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .full_i      (full),
    .push_o      (push),
    .entry_o     (entry)
  );

  jac_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (entry),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  jac_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .value_o      (value_o),
    .key_event_o  (key_event_o)
  );

endmodule
